// ===== sv/rtv_pkg.sv =====
// Shared types, constants and lookup functions for the release tag validator.
package rtv_pkg;

	localparam int MAX_TAG_BYTES = 255;
	localparam int POS_W = $clog2(MAX_TAG_BYTES + 2);
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int CAP_W = 9;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TAG_BYTES);
	localparam logic [POS_W-1:0] MIN_TAG_LEN = POS_W'(24);
	localparam logic [POS_W-1:0] PREFIX_LEN = POS_W'(10);
	localparam logic [POS_W-1:0] YEAR_HI_TENS = POS_W'(10);
	localparam logic [POS_W-1:0] YEAR_HI_UNITS = POS_W'(11);
	localparam logic [POS_W-1:0] YEAR_LO_TENS = POS_W'(12);
	localparam logic [POS_W-1:0] YEAR_LO_UNITS = POS_W'(13);
	localparam logic [POS_W-1:0] SEP_MONTH = POS_W'(14);
	localparam logic [POS_W-1:0] SEP_DAY = POS_W'(17);
	localparam logic [POS_W-1:0] SEP_FIELD = POS_W'(20);
	localparam logic [POS_W-1:0] TAG_LEN_SAT = POS_W'(255);

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [6:0] MONTHS = 7'd12;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic       tag_valid;
		logic [7:0] tag_length;
	} out_t;

	// One unit of work for the parser: an optional held CR, an optional kept
	// byte, and the end of the locator.
	typedef struct packed {
		logic [7:0] byte_value;
		logic       pre_cr;
		logic       keep;
		logic       fin;
	} op_t;

	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h62; // b
			4'd1:    ch = 8'h6C; // l
			4'd2:    ch = 8'h6F; // o
			4'd3:    ch = 8'h63; // c
			4'd4:    ch = 8'h6B; // k
			4'd5:    ch = 8'h6C; // l
			4'd6:    ch = 8'h69; // i
			4'd7:    ch = 8'h73; // s
			4'd8:    ch = 8'h74; // t
			4'd9:    ch = CH_DASH;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] month);
		logic [4:0] d;
		case (month)
			4'd2:                 d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default:              d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

// ===== sv/rtv_front.sv =====
// Front end: takes raw bytes, holds back a possible final CR and issues parser work.
module rtv_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  rtv_pkg::in_t  item,
	output logic          push,
	output rtv_pkg::op_t  op
);
	import rtv_pkg::*;

	logic pending_q;
	logic is_cr;
	logic is_lf;

	assign is_cr = (item.byte_value == CH_CR);
	assign is_lf = (item.byte_value == CH_LF);

	always_comb begin
		op.byte_value = item.byte_value;
		op.pre_cr = pending_q;
		op.keep = 1'b1;
		op.fin = item.last_byte;
		push = take;
		if (item.last_byte) begin
			// a final LF strips itself and any held CR
			if (is_lf) begin
				op.keep = 1'b0;
				op.pre_cr = 1'b0;
			end
		end else if (is_cr) begin
			// hold the new CR; release the old one as a stray byte
			op.keep = 1'b0;
			push = take && pending_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (take) begin
			pending_q <= is_cr && !item.last_byte;
		end
	end

endmodule

// ===== sv/rtv_fifo.sv =====
// Short queue of parser work between the front end and the parser.
module rtv_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rtv_pkg::op_t  push_op,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output rtv_pkg::op_t  pop_op
);
	import rtv_pkg::*;

	op_t                   slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_op = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !pop) |=> pop_valid)
		else $error("pushed transaction not visible");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with unequal pointers");

endmodule

// ===== sv/rtv_exec.sv =====
// Parser: checks kept bytes against the tag grammar and registers the verdict.
module rtv_exec (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cap_we,
	input  logic [rtv_pkg::CAP_W-1:0] cap_wdata,
	input  logic                      op_valid,
	input  rtv_pkg::op_t              op,
	output logic                      op_take,
	output logic                      res_valid,
	input  logic                      res_stall,
	output rtv_pkg::out_t             res
);
	import rtv_pkg::*;

	typedef enum logic [1:0] {PH_DATE, PH_A, PH_B} phase_t;

	logic [CAP_W-1:0] cap_q;
	logic [POS_W-1:0] pos_q;
	phase_t           phase_q;
	logic [6:0]       mon_q;
	logic [6:0]       day_q;
	logic             fhd_q;
	logic             err_q;
	logic             yt_lsb_q;   // tens digit lsb of the current year pair
	logic             yt_zero_q;  // tens digit of the current year pair is zero
	logic             yhi4_q;
	logic             ylo4_q;
	logic             yloz_q;
	logic             ynz_q;
	logic             res_valid_q;
	out_t             res_q;

	logic [POS_W-1:0] pos1, pos2, p;
	phase_t           phase_n;
	logic [6:0]       mon_n, day_n;
	logic             fhd_n, err_n, yt_lsb_n, yt_zero_n, yhi4_n, ylo4_n, yloz_n, ynz_n;
	logic [7:0]       c;
	logic [3:0]       digit;
	logic             is_dec;
	logic             pair_div4;
	logic             leap;
	logic [5:0]       day_limit;
	logic             date_ok;
	logic             len_ok;
	logic             verdict;
	logic [7:0]       len_sat;

	// only the end of a locator needs the result register
	assign op_take = op_valid && (!op.fin || !res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign c = op.byte_value;
	assign digit = c[3:0];
	assign is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
	assign pair_div4 = ({yt_lsb_q, 1'b0} + c[1:0]) == 2'b00;

	assign leap = (ylo4_q && !yloz_q) || (yloz_q && yhi4_q);
	assign day_limit = {1'b0, month_days(mon_q[3:0])}
		+ 6'((mon_q == 7'd2) && leap);
	assign date_ok = ynz_q && (mon_q != '0) && (mon_q <= MONTHS)
		&& (day_q != '0) && (day_q <= {1'b0, day_limit});

	always_comb begin
		phase_n = phase_q;
		mon_n = mon_q;
		day_n = day_q;
		fhd_n = fhd_q;
		err_n = err_q;
		yt_lsb_n = yt_lsb_q;
		yt_zero_n = yt_zero_q;
		yhi4_n = yhi4_q;
		ylo4_n = ylo4_q;
		yloz_n = yloz_q;
		ynz_n = ynz_q;
		// a held CR is always a stray byte: only its length still matters
		pos1 = pos_q;
		if (op.pre_cr) begin
			err_n = 1'b1;
			if (pos_q <= POS_MAX) begin
				pos1 = pos_q + 1'b1;
			end
		end
		p = pos1;
		pos2 = pos1;
		if (op.keep) begin
			if (pos1 <= POS_MAX) begin
				pos2 = pos1 + 1'b1;
			end
			if (p > POS_MAX) begin
				err_n = 1'b1;
			end else begin
				if (c == CH_CR || c == CH_LF) begin
					err_n = 1'b1;
				end
				unique case (phase_q)
					PH_DATE: begin
						if (p < PREFIX_LEN) begin
							if (c != prefix_char(p[3:0])) begin
								err_n = 1'b1;
							end
						end else if (p == SEP_MONTH || p == SEP_DAY) begin
							if (c != CH_DASH) begin
								err_n = 1'b1;
							end
						end else if (p == SEP_FIELD) begin
							if (c != CH_DASH || !date_ok) begin
								err_n = 1'b1;
							end
							phase_n = PH_A;
							fhd_n = 1'b0;
						end else if (!is_dec) begin
							err_n = 1'b1;
						end else if (p < SEP_MONTH) begin
							if (digit != 4'd0) begin
								ynz_n = 1'b1;
							end
							if (p == YEAR_HI_TENS || p == YEAR_LO_TENS) begin
								yt_lsb_n = c[0];
								yt_zero_n = (digit == 4'd0);
							end else if (p == YEAR_HI_UNITS) begin
								yhi4_n = pair_div4;
							end else if (p == YEAR_LO_UNITS) begin
								ylo4_n = pair_div4;
								yloz_n = yt_zero_q && (digit == 4'd0);
							end
						end else if (p < SEP_DAY) begin
							mon_n = 7'(mon_q * 7'd10 + 7'(digit));
						end else begin
							day_n = 7'(day_q * 7'd10 + 7'(digit));
						end
					end
					PH_A, PH_B: begin
						if (is_dec) begin
							if (!fhd_q && c == CH_ZERO) begin
								err_n = 1'b1;
							end
							fhd_n = 1'b1;
						end else if (c == CH_DASH && phase_q == PH_A) begin
							if (!fhd_q) begin
								err_n = 1'b1;
							end
							phase_n = PH_B;
							fhd_n = 1'b0;
						end else begin
							err_n = 1'b1;
						end
					end
					default: err_n = 1'b1;
				endcase
			end
		end
	end

	assign len_ok = (pos2 >= MIN_TAG_LEN) && (pos2 <= POS_MAX)
		&& ({1'b0, pos2} + 1'b1 <= (POS_W + 1)'(cap_q));
	assign verdict = !err_n && len_ok && (phase_n == PH_B) && fhd_n;
	assign len_sat = (pos2 > TAG_LEN_SAT) ? 8'hFF : pos2[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(256);
			pos_q <= '0;
			phase_q <= PH_DATE;
			mon_q <= '0;
			day_q <= '0;
			fhd_q <= 1'b0;
			err_q <= 1'b0;
			yt_lsb_q <= 1'b0;
			yt_zero_q <= 1'b0;
			yhi4_q <= 1'b0;
			ylo4_q <= 1'b0;
			yloz_q <= 1'b0;
			ynz_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
			if (op_take && op.fin) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (op_take) begin
				if (op.fin) begin
					// post the verdict and clear for the next locator
					res_q.tag_valid <= verdict;
					res_q.tag_length <= len_sat;
					pos_q <= '0;
					phase_q <= PH_DATE;
					mon_q <= '0;
					day_q <= '0;
					fhd_q <= 1'b0;
					err_q <= 1'b0;
					yt_lsb_q <= 1'b0;
					yt_zero_q <= 1'b0;
					yhi4_q <= 1'b0;
					ylo4_q <= 1'b0;
					yloz_q <= 1'b0;
					ynz_q <= 1'b0;
				end else begin
					pos_q <= pos2;
					phase_q <= phase_n;
					mon_q <= mon_n;
					day_q <= day_n;
					fhd_q <= fhd_n;
					err_q <= err_n;
					yt_lsb_q <= yt_lsb_n;
					yt_zero_q <= yt_zero_n;
					yhi4_q <= yhi4_n;
					ylo4_q <= ylo4_n;
					yloz_q <= yloz_n;
					ynz_q <= ynz_n;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX + 1'b1)
		else $error("byte position beyond saturation");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_DATE) |-> (pos_q > SEP_FIELD))
		else $error("field phase entered before the date ended");
	assert property (@(posedge clk) disable iff (!arst_n)
		(op_take && op.fin) |=> (res_valid_q && pos_q == '0 && phase_q == PH_DATE))
		else $error("end of locator did not post a verdict and clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_q.tag_valid && res_valid_q |-> (res_q.tag_length >= 8'(MIN_TAG_LEN)))
		else $error("valid verdict with short length");

endmodule

// ===== sv/release_tag_validator.sv =====
// Top level of the release tag validator: front end, work queue and parser.
//
// Bytes of a release locator enter on the byte channel (byte_valid, byte_stall,
// byte_data) with last_byte marking the final byte of each locator. One verdict
// per locator leaves on the verdict channel (verdict_valid, verdict_stall,
// verdict) holding tag_valid and the stripped, saturated tag_length.
// Throughput: one byte per cycle while byte_stall is low; every per-byte check
// is combinational in the parser and the two-entry queue lets front and parser
// run apart. With the queue empty, the final byte is first written into the
// queue and the verdict is then registered in the parser.
// The buffer capacity is written through cap_we / cap_wdata, by the user only
// while no locator is in flight (the block does not enforce this); reset sets it to 256.
// Reset clears the held CR, the queue, all parse state and any pending verdict.
// While the receiver stalls, the verdict holds; the parser keeps taking work
// until a second verdict would be needed, then the queue fills and byte_stall
// rises until the verdict is taken.
module release_tag_validator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cap_we,
	input  logic [rtv_pkg::CAP_W-1:0] cap_wdata,
	input  logic                      byte_valid,
	output logic                      byte_stall,
	input  rtv_pkg::in_t              byte_data,
	output logic                      verdict_valid,
	input  logic                      verdict_stall,
	output rtv_pkg::out_t             verdict
);
	import rtv_pkg::*;

	logic q_full;
	logic take;
	logic push;
	op_t  push_op;
	logic pop_valid;
	op_t  pop_op;
	logic pop;

	assign byte_stall = q_full;
	assign take = byte_valid && !q_full;

	rtv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (byte_data),
		.push   (push),
		.op     (push_op)
	);

	rtv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_op    (pop_op)
	);

	rtv_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap_we    (cap_we),
		.cap_wdata (cap_wdata),
		.op_valid  (pop_valid),
		.op        (pop_op),
		.op_take   (pop),
		.res_valid (verdict_valid),
		.res_stall (verdict_stall),
		.res       (verdict)
	);

endmodule

// ===== test/tb_release_tag_validator.sv =====
// Self-checking testbench for the release tag validator: directed and random locators.
`timescale 1ns / 1ps

module tb_release_tag_validator;

	import rtv_pkg::*;

	typedef logic [7:0] text_t[$];
	typedef enum {END_BARE, END_LF, END_CRLF, END_CR} ending_e;
	typedef enum logic [1:0] {PH_DATE, PH_FIRST, PH_SECOND} parse_ph_e;

	localparam int unsigned TAG_MAX = MAX_TAG_BYTES;
	localparam int unsigned SHORTEST_TAG = 24;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cap_we = 1'b0;
	logic [CAP_W-1:0] cap_wdata = '0;
	logic           byte_valid = 1'b0;
	logic           byte_stall;
	in_t            byte_data = '0;
	logic           verdict_valid;
	logic           verdict_stall = 1'b0;
	out_t           verdict;

	in_t            pending_bytes[$];
	out_t           expected_verdicts[$];
	text_t          draft;
	out_t           want;
	bit             byte_taken = 1'b0;
	bit             hold_go = 1'b0;
	bit             hold_off = 1'b0;
	int unsigned    tx_idle_pct = 0;
	int unsigned    rx_idle_pct = 0;
	int unsigned    sent_bytes = 0;
	int unsigned    fail_count = 0;

	// Local copy of the parser state and the capacity register
	string          tag_head = "blocklist-";
	int unsigned    cap_size = 256;
	int unsigned    kept_count = 0;
	parse_ph_e      parse_ph = PH_DATE;
	logic [13:0]    year_acc = '0;
	logic [6:0]     month_acc = '0;
	logic [6:0]     day_acc = '0;
	bit             field_digit = 1'b0;
	bit             cr_held = 1'b0;
	bit             tag_bad = 1'b0;

	release_tag_validator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cap_we        (cap_we),
		.cap_wdata     (cap_wdata),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_data     (byte_data),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict       (verdict)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
		bit leap;
		leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
		case (m)
			2:             return leap ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	function automatic bit date_fits();
		if (year_acc == 0 || month_acc == 0 || month_acc > 12)
			return 1'b0;
		return day_acc != 0 && day_acc <= days_in_month(month_acc, year_acc);
	endfunction

	function automatic void number_field_byte(logic [7:0] c, bit dash_ends);
		if (is_digit(c)) begin
			if (!field_digit && c == CH_ZERO)
				tag_bad = 1'b1;
			field_digit = 1'b1;
		end else if (c == CH_DASH && dash_ends) begin
			if (!field_digit)
				tag_bad = 1'b1;
			parse_ph = PH_SECOND;
			field_digit = 1'b0;
		end else begin
			tag_bad = 1'b1;
		end
	endfunction

	// Take one byte that stays in the stripped tag
	function automatic void keep_tag_byte(logic [7:0] c);
		int unsigned p;
		p = kept_count;
		if (kept_count <= TAG_MAX)
			kept_count++;
		if (p > TAG_MAX) begin
			tag_bad = 1'b1;
			return;
		end
		if (c == CH_CR || c == CH_LF)
			tag_bad = 1'b1;
		case (parse_ph)
			PH_DATE: begin
				if (p < 10) begin
					if (c != tag_head[p])
						tag_bad = 1'b1;
				end else if (p == 14 || p == 17) begin
					if (c != CH_DASH)
						tag_bad = 1'b1;
				end else if (p == 20) begin
					if (c != CH_DASH || !date_fits())
						tag_bad = 1'b1;
					parse_ph = PH_FIRST;
					field_digit = 1'b0;
				end else if (!is_digit(c)) begin
					tag_bad = 1'b1;
				end else if (p < 14) begin
					year_acc = year_acc * 14'd10 + 14'(c - CH_ZERO);
				end else if (p < 17) begin
					month_acc = month_acc * 7'd10 + 7'(c - CH_ZERO);
				end else begin
					day_acc = day_acc * 7'd10 + 7'(c - CH_ZERO);
				end
			end
			PH_FIRST: number_field_byte(c, 1'b1);
			default:  number_field_byte(c, 1'b0);
		endcase
	endfunction

	// Advance the parser by one accepted transaction; the final byte yields a verdict
	function automatic void parse_locator_byte(in_t t);
		out_t v;
		int unsigned n;
		if (!t.last_byte) begin
			if (cr_held) begin
				cr_held = 1'b0;
				keep_tag_byte(CH_CR);
			end
			if (t.byte_value == CH_CR)
				cr_held = 1'b1;
			else
				keep_tag_byte(t.byte_value);
			return;
		end
		if (t.byte_value != CH_LF) begin
			if (cr_held)
				keep_tag_byte(CH_CR);
			keep_tag_byte(t.byte_value);
		end
		n = kept_count;
		v.tag_valid = !tag_bad && n >= SHORTEST_TAG && n <= TAG_MAX && n + 1 <= cap_size
			&& parse_ph == PH_SECOND && field_digit;
		v.tag_length = (n > 255) ? 8'd255 : n[7:0];
		expected_verdicts.push_back(v);
		kept_count = 0;
		parse_ph = PH_DATE;
		year_acc = '0;
		month_acc = '0;
		day_acc = '0;
		field_digit = 1'b0;
		cr_held = 1'b0;
		tag_bad = 1'b0;
	endfunction

	function automatic void log_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Sample both channels; predict on accepted bytes, compare accepted verdicts
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				byte_taken = 1'b1;
				parse_locator_byte(byte_data);
			end
			if (verdict_valid && !verdict_stall) begin
				if (expected_verdicts.size() == 0) begin
					log_failure($sformatf("verdict with none expected: valid=%0b length=%0d",
						verdict.tag_valid, verdict.tag_length));
				end else begin
					want = expected_verdicts.pop_front();
					if (verdict.tag_valid !== want.tag_valid)
						log_failure($sformatf("tag_valid mismatch: expected %0b, got %0b",
							want.tag_valid, verdict.tag_valid));
					if (verdict.tag_length !== want.tag_length)
						log_failure($sformatf("tag_length mismatch: expected %0d, got %0d",
							want.tag_length, verdict.tag_length));
				end
			end
		end
	end

	// Byte driver: hold a stalled transaction, otherwise offer the next one or idle
	always @(negedge clk) begin
		if (arst_n && (!byte_valid || byte_taken)) begin
			if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				byte_valid <= 1'b1;
				byte_data <= pending_bytes.pop_front();
			end else begin
				byte_valid <= 1'b0;
			end
		end
		byte_taken = 1'b0;
	end

	always @(negedge clk)
		verdict_stall <= hold_off || ($urandom_range(0, 99) < rx_idle_pct);

	// Long receiver hold-off so that the queue fills and the input stalls
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void start_text(string s);
		draft.delete();
		for (int i = 0; i < s.len(); i++)
			draft.push_back(s[i]);
	endfunction

	function automatic void add_digits(int unsigned n, bit lead_zero_ok);
		for (int unsigned i = 0; i < n; i++)
			draft.push_back(8'(CH_ZERO + ((i == 0 && !lead_zero_ok) ?
				$urandom_range(1, 9) : $urandom_range(0, 9))));
	endfunction

	function automatic void queue_locator(ending_e how);
		in_t it;
		case (how)
			END_LF:   draft.push_back(CH_LF);
			END_CRLF: begin
				draft.push_back(CH_CR);
				draft.push_back(CH_LF);
			end
			END_CR:   draft.push_back(CH_CR);
			default:  ;
		endcase
		if (draft.size() == 0)
			draft.push_back(CH_LF);
		foreach (draft[i]) begin
			it.byte_value = draft[i];
			it.last_byte = (i == draft.size() - 1);
			pending_bytes.push_back(it);
		end
		sent_bytes += draft.size();
	endfunction

	function automatic void add_number_field();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return;
		if (roll < 15)
			draft.push_back(CH_ZERO);
		else
			add_digits(1, 1'b0);
		if ($urandom_range(0, 99) < 3)
			add_digits($urandom_range(20, 240), 1'b1);
		else
			add_digits($urandom_range(0, 4), 1'b1);
	endfunction

	function automatic void build_random_locator();
		int unsigned yr, mo, dy, roll, k;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			// noise: random bytes with a fair share of line endings
			draft.delete();
			k = $urandom_range(1, 40);
			repeat (k) begin
				if ($urandom_range(0, 9) == 0)
					draft.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
				else
					draft.push_back(8'($urandom_range(0, 255)));
			end
			return;
		end
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			yr = 0;
		end else if (roll < 30) begin
			case ($urandom_range(0, 5))
				0:       yr = 1900;
				1:       yr = 2000;
				2:       yr = 2100;
				3:       yr = 2400;
				4:       yr = 2024;
				default: yr = 1600;
			endcase
		end else begin
			yr = $urandom_range(1, 9999);
		end
		roll = $urandom_range(0, 99);
		mo = (roll < 85) ? $urandom_range(1, 12) : (roll < 92) ? 0 : $urandom_range(13, 99);
		roll = $urandom_range(0, 99);
		dy = (roll < 75) ? $urandom_range(1, 31) : (roll < 85) ? 0 : $urandom_range(32, 99);
		if ($urandom_range(0, 99) < 15) begin
			mo = 2;
			dy = $urandom_range(28, 30);
		end
		start_text($sformatf("blocklist-%04d-%02d-%02d-", yr, mo, dy));
		add_number_field();
		draft.push_back(CH_DASH);
		add_number_field();
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (roll < 11) begin
			draft[$urandom_range(0, draft.size() - 1)] = $urandom_range(0, 1) ? CH_CR : CH_LF;
		end else if (roll < 15) begin
			k = $urandom_range(1, draft.size() - 1);
			while (draft.size() > k)
				void'(draft.pop_back());
		end else if (roll < 18) begin
			draft.push_back($urandom_range(0, 1) ? CH_DASH : 8'($urandom_range(32, 126)));
		end
	endfunction

	function automatic ending_e random_ending();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return END_BARE;
		if (roll < 75)
			return END_LF;
		if (roll < 93)
			return END_CRLF;
		if (roll < 97)
			return END_CR;
		draft.delete();
		return END_LF;
	endfunction

	task automatic drain_and_settle();
		while (pending_bytes.size() != 0 || byte_valid || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(int unsigned v);
		@(negedge clk);
		cap_we <= 1'b1;
		cap_wdata <= v[CAP_W-1:0];
		@(negedge clk);
		cap_we <= 1'b0;
		cap_size = v;
	endtask

	initial begin
		int unsigned goal;
		ending_e how;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		tx_idle_pct = 15;
		rx_idle_pct = 57;

		start_text("blocklist-2024-02-29-1-2");
		queue_locator(END_BARE);
		start_text("blocklist-2023-12-31-9-87");
		queue_locator(END_LF);
		start_text("blocklist-2000-02-29-10-20");
		queue_locator(END_CRLF);
		start_text("blocklist-1900-02-29-1-2");
		queue_locator(END_BARE);
		start_text("blocklist-0000-01-01-1-2");
		queue_locator(END_BARE);
		start_text("blocklist-2024-13-01-1-2");
		queue_locator(END_LF);
		start_text("blocklist-2024-00-10-1-2");
		queue_locator(END_BARE);
		start_text("blocklist-2024-04-31-1-2");
		queue_locator(END_BARE);
		start_text("blocklist-2024-01-00-1-2");
		queue_locator(END_BARE);
		start_text("blocklist-2024-01-01-01-2");
		queue_locator(END_BARE);
		start_text("blocklist-2024-01-01--2");
		queue_locator(END_LF);
		start_text("blocklist-2024-01-01-12-");
		queue_locator(END_BARE);
		// held CR that is not followed by the final LF
		start_text("blocklist-2024-01-01-1-2");
		draft[22] = CH_CR;
		queue_locator(END_BARE);
		start_text("blocklist-2024-01-01-1-2");
		draft[21] = CH_LF;
		queue_locator(END_BARE);
		start_text("blocklist-2024-01-01-1-2");
		queue_locator(END_CR);
		start_text("blocklist-2024-01-01-1");
		queue_locator(END_LF);
		draft.delete();
		queue_locator(END_LF);
		// longest tag that still fits, then just over, then well over
		start_text("blocklist-2024-01-01-7-");
		add_digits(TAG_MAX - 23, 1'b0);
		queue_locator(END_CRLF);
		start_text("blocklist-2024-01-01-7-");
		add_digits(TAG_MAX - 22, 1'b0);
		queue_locator(END_BARE);
		start_text("blocklist-2024-01-01-7-");
		add_digits(277, 1'b0);
		queue_locator(END_LF);
		start_text("blocklist-2024-01-01-1-2");
		draft[0] = 8'h00;
		draft[23] = 8'hFF;
		queue_locator(END_BARE);
		start_text("Blocklist-2024-01-01-1-2");
		queue_locator(END_BARE);
		drain_and_settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					tx_idle_pct = 15;
					rx_idle_pct = 57;
				end
				1: begin
					tx_idle_pct = 57;
					rx_idle_pct = 15;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			case (ph)
				0:       write_capacity(511);
				1:       write_capacity(1);
				2:       write_capacity(25);
				3:       write_capacity(0);
				4:       write_capacity(256);
				default: write_capacity($urandom_range(24, 60));
			endcase
			goal = sent_bytes + 120;
			while (sent_bytes < goal) begin
				build_random_locator();
				how = random_ending();
				queue_locator(how);
			end
			if (ph == 4)
				hold_go = 1'b1;
			drain_and_settle();
		end

		repeat (8) @(posedge clk);
		if (expected_verdicts.size() != 0)
			log_failure($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
